@@ hw/rtl/pp2argb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pp2argb_pkg
// Shared types, codes and colour widening helpers for the palette pixel
// to ARGB converter.
// ----------------------------------------------------------------------------
package pp2argb_pkg;

   localparam int unsigned PAL_DEPTH   = 256;
   localparam int unsigned PAL_IDX_W   = 8;
   localparam int unsigned CHAN_W      = 6;
   localparam int unsigned ENTRY_W     = 3 * CHAN_W;
   localparam int unsigned PIX_W       = 24;
   localparam int unsigned ARGB_W      = 32;
   localparam int unsigned FMT_W       = 3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // request kind
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_PAL_WR = 1'b1;

   // palette channel select
   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2,
      CH_NONE  = 2'd3
   } chan_type;

   // source pixel format
   typedef enum logic [FMT_W-1:0] {
      FMT_INDEXED = 3'd0,
      FMT_RGB555  = 3'd1,
      FMT_RGB565  = 3'd2,
      FMT_BGR24   = 3'd3,
      FMT_BLACK   = 3'd4
   } fmt_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

endpackage

@@ hw/rtl/palette_pixel_to_argb_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_pixel_to_argb_converter
// VGA DAC style 256 x 18-bit palette plus pixel decode to opaque ARGB8888.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per handshake. kind 0 converts req_pixel_bytes
//            according to the format register and yields one response;
//            kind 1 writes the low six bits of req_palette_value into one
//            channel of palette entry req_palette_index and yields nothing.
//            Channel 3 writes are dropped.
//   rsp_*  : converted colour, alpha 0xFF in bits 31:24.
//   csr_*  : format register write (always ready); only change it while
//            no pixel request is in flight.
//   Path: a pixel request accepted by the handshake passes through the palette
//   read register, then the response register, before it shows on rsp_valid.
//   Throughput: one request per cycle unless stalled, set by one palette read port.
//   A palette write takes effect at its accept edge, so a pixel request in
//   the very next cycle sees it.
//   Reset: format returns to indexed 8bpp; a per-entry valid bit makes every
//   palette entry read as zero until written, so no clearing pass is needed.
//   Stall: a held response keeps the one staged pixel in place; req_ready
//   drops only when both stages are full and rsp_ready is low.
// ----------------------------------------------------------------------------
module palette_pixel_to_argb_converter
   import pp2argb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [PIX_W-1:0]     req_pixel_bytes,
   input  logic [PAL_IDX_W-1:0] req_palette_index,
   input  logic [1:0]           req_palette_channel,
   input  logic [7:0]           req_palette_value,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ARGB_W-1:0]    rsp_argb,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [FMT_W-1:0]     csr_pixel_format
);

   logic [FMT_W-1:0]   pixel_format_ff, pixel_format_in;

   logic [ENTRY_W-1:0] palette_mem [PAL_DEPTH];
   logic               entry_valid_ff [PAL_DEPTH];

   logic               s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]   s1_bytes_ff;
   logic [ENTRY_W-1:0] s1_entry_ff;
   logic               s1_hit_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ARGB_W-1:0]  rsp_argb_ff;

   logic               out_load;
   logic               s1_load;
   logic               req_fire;
   logic               pix_fire;
   logic               pal_wr;
   logic [CHAN_W-1:0]  wr_val;
   chan_type           wr_chan;
   logic [ENTRY_W-1:0] fresh_entry;

   logic [ENTRY_W-1:0] entry;
   logic [15:0]        half;
   logic [7:0]         red, green, blue;

   // ---------------------------------------------------------------- control
   assign csr_ready = 1'b1;
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign s1_load   = !s1_valid_ff || out_load;
   assign req_ready = s1_load;
   assign req_fire  = req_valid && req_ready;
   assign pix_fire  = req_fire && (req_kind == KIND_PIXEL);
   assign wr_chan   = chan_type'(req_palette_channel);
   assign pal_wr    = req_fire && (req_kind == KIND_PAL_WR) && (wr_chan != CH_NONE);
   assign wr_val    = req_palette_value[CHAN_W-1:0];

   always_comb begin
      pixel_format_in = pixel_format_ff;
      if (csr_valid && csr_ready) begin
         pixel_format_in = csr_pixel_format;
      end
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = pix_fire;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_INDEXED;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pixel_format_ff <= pixel_format_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- palette
   // first write to an entry stores the whole word so the other channels
   // start from zero; later writes touch one channel only
   always_comb begin
      fresh_entry = '0;
      unique case (wr_chan)
         CH_RED:   fresh_entry[3*CHAN_W-1:2*CHAN_W] = wr_val;
         CH_GREEN: fresh_entry[2*CHAN_W-1:CHAN_W]   = wr_val;
         CH_BLUE:  fresh_entry[CHAN_W-1:0]          = wr_val;
         default:  fresh_entry = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pal_wr) begin
         if (!entry_valid_ff[req_palette_index]) begin
            palette_mem[req_palette_index] <= fresh_entry;
         end else begin
            unique case (wr_chan)
               CH_RED:   palette_mem[req_palette_index][3*CHAN_W-1:2*CHAN_W] <= wr_val;
               CH_GREEN: palette_mem[req_palette_index][2*CHAN_W-1:CHAN_W]   <= wr_val;
               CH_BLUE:  palette_mem[req_palette_index][CHAN_W-1:0]          <= wr_val;
               default:  ;
            endcase
         end
      end
      if (pix_fire) begin
         s1_entry_ff <= palette_mem[req_pixel_bytes[PAL_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAL_DEPTH; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (pal_wr) begin
         entry_valid_ff[req_palette_index] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (pix_fire) begin
         s1_bytes_ff <= req_pixel_bytes;
         s1_hit_ff   <= entry_valid_ff[req_pixel_bytes[PAL_IDX_W-1:0]];
      end
   end

   // ---------------------------------------------------------------- decode
   assign entry = s1_hit_ff ? s1_entry_ff : '0;
   assign half  = s1_bytes_ff[15:0];

   always_comb begin
      red   = '0;
      green = '0;
      blue  = '0;
      unique case (pixel_format_ff)
         FMT_INDEXED: begin
            red   = widen6(entry[3*CHAN_W-1:2*CHAN_W]);
            green = widen6(entry[2*CHAN_W-1:CHAN_W]);
            blue  = widen6(entry[CHAN_W-1:0]);
         end
         FMT_RGB555: begin
            red   = widen5(half[14:10]);
            green = widen5(half[9:5]);
            blue  = widen5(half[4:0]);
         end
         FMT_RGB565: begin
            red   = widen5(half[15:11]);
            green = widen6(half[10:5]);
            blue  = widen5(half[4:0]);
         end
         FMT_BGR24: begin
            red   = s1_bytes_ff[23:16];
            green = s1_bytes_ff[15:8];
            blue  = s1_bytes_ff[7:0];
         end
         default: begin
            red   = '0;
            green = '0;
            blue  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         rsp_argb_ff <= {ALPHA_OPAQUE, red, green, blue};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_argb  = rsp_argb_ff;

   // ---------------------------------------------------------------- checks
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |=> (s1_valid_ff && $stable(s1_bytes_ff)))
      else $error("staged pixel lost while response stalled");

   a_entry_marked: assert property (@(posedge clock) disable iff (reset)
      pal_wr |=> entry_valid_ff[$past(req_palette_index)])
      else $error("palette entry not marked after write");

   a_alpha_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_argb_ff[31:24] == ALPHA_OPAQUE))
      else $error("response alpha not opaque");

endmodule
